### src/aes_pkg.sv
// Package: AES constants, S-box and round helper functions.
package aes_pkg;

  localparam int NumRounds = 14;
  localparam int KeyRegs   = 4;

  typedef logic [127:0] blk_t;
  typedef logic [255:0] key_t;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of the block sits at bits 127-8k .. 120-8k
  function automatic blk_t sub_shift(input blk_t s);
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(c*4+r) -: 8] = sbox(s[127-8*((((c+r)%4)*4)+r) -: 8]);
      end
    end
    return o;
  endfunction

  function automatic blk_t mix_cols(input blk_t s);
    blk_t o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      o[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return o;
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

### src/aes_round_cell.sv
// One cipher round cell: round transform on the block, one key-schedule step.
module aes_round_cell import aes_pkg::*; #(
  parameter bit LAST = 1'b0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  blk_t       in_state,
  input  key_t       in_key,   // previous two round keys, older in high half
  input  logic [7:0] in_rcon,
  input  logic       in_odd,   // next key word comes from the SubWord-only step
  output logic       out_vld,
  output blk_t       out_state,
  output key_t       out_key,
  output logic [7:0] out_rcon,
  output logic       out_odd
);

  logic        vld_r;
  blk_t        state_r;
  key_t        key_r;
  logic [7:0]  rcon_r;
  logic        odd_r;
  blk_t        st_sub, st_mix;
  logic [127:0] rk_new;
  logic [31:0] t;
  logic [7:0]  rcon_nxt;
  logic [31:0] last_w;

  // round key used by this cell is the lower half of in_key
  always_comb begin
    st_sub = sub_shift(in_state);
    st_mix = LAST ? st_sub : mix_cols(st_sub);
    last_w = in_key[31:0];
    if (in_odd) begin
      t = sbox_word(last_w);
      rcon_nxt = in_rcon;
    end else begin
      t = sbox_word({last_w[23:0], last_w[31:24]}) ^ {in_rcon, 24'h0};
      rcon_nxt = xtime(in_rcon);
    end
    rk_new[127:96] = in_key[255:224] ^ t;
    rk_new[95:64]  = in_key[223:192] ^ rk_new[127:96];
    rk_new[63:32]  = in_key[191:160] ^ rk_new[95:64];
    rk_new[31:0]   = in_key[159:128] ^ rk_new[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= st_mix ^ in_key[127:0];
      key_r   <= {in_key[127:0], rk_new};
      rcon_r  <= rcon_nxt;
      odd_r   <= ~in_odd;
    end
  end

  assign out_vld   = vld_r;
  assign out_state = state_r;
  assign out_key   = key_r;
  assign out_rcon  = rcon_r;
  assign out_odd   = odd_r;

endmodule

### src/aes256_block_encrypt.sv
// Top level: AES-256 encryption as a chain of fourteen round cells.
// Path: one input stage plus fourteen round cells, each registered; the whole
// chain holds while the output side stalls.
// Throughput: one block per cycle; the whole chain advances when the output
// register is empty or being taken.
// Reset (rst_n, synchronous) clears valid flags and the key registers to zero.
module aes256_block_encrypt import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // plain_upper [63:0], plain_lower [127:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // cipher_upper [63:0], cipher_lower [127:64]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [63:0] key_r [KeyRegs];
  logic        wr;
  reg_idx_t    widx;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel & cfg_penable & cfg_pwrite & (cfg_paddr[2:0] == 3'd0);
  assign widx = reg_idx_t'(cfg_paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KeyRegs; i++) key_r[i] <= '0;
    end else if (wr) begin
      key_r[widx] <= cfg_pwdata;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2:0] == 3'd0) begin
      unique case (widx)
        REG_KEY0: cfg_prdata = key_r[0];
        REG_KEY1: cfg_prdata = key_r[1];
        REG_KEY2: cfg_prdata = key_r[2];
        REG_KEY3: cfg_prdata = key_r[3];
        default:  cfg_prdata = '0;
      endcase
    end
  end

  // chain advances whenever the last stage is empty or being drained
  logic en;
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  logic       v   [NumRounds+1];
  blk_t       s   [NumRounds+1];
  key_t       k   [NumRounds+1];
  logic [7:0] rc  [NumRounds+1];
  logic       od  [NumRounds+1];

  // input stage: initial AddRoundKey, load the full key into the schedule
  logic v0_r;
  blk_t s0_r;
  key_t k0_r;
  key_t key_all;
  assign key_all = {key_r[0], key_r[1], key_r[2], key_r[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= {in_tdata[63:0], in_tdata[127:64]} ^ key_all[255:128];
      k0_r <= key_all;
    end
  end

  assign v[0]  = v0_r;
  assign s[0]  = s0_r;
  assign k[0]  = k0_r;
  assign rc[0] = 8'h01;
  assign od[0] = 1'b0;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round_cell #(.LAST(g == NumRounds-1)) u_cell (
      .clk, .rst_n, .en,
      .in_vld(v[g]), .in_state(s[g]), .in_key(k[g]), .in_rcon(rc[g]), .in_odd(od[g]),
      .out_vld(v[g+1]), .out_state(s[g+1]), .out_key(k[g+1]),
      .out_rcon(rc[g+1]), .out_odd(od[g+1])
    );
  end

  assign out_tvalid = v[NumRounds];
  assign out_tdata  = {s[NumRounds][63:0], s[NumRounds][127:64]};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");
  a_stall_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> v[1] == $past(v[1]))
    else $error("chain moved during stall");

endmodule
